@@ hdl/pic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    // Bus operation carried by one input beat
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_ACK    = 2'd3
    } op_t;

    // Initialization sequence position: which ICW the data port expects next
    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_ICW2  = 2'd1,
        PH_ICW3  = 2'd2,
        PH_ICW4  = 2'd3
    } phase_t;

    // Port select codes
    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    // Command-port bit positions
    localparam int ICW1_BIT     = 4;  // ICW1 marker
    localparam int OCW3_BIT     = 3;  // OCW3 marker
    localparam int OCW2_EOI_BIT = 5;  // end of interrupt
    localparam int OCW2_SL_BIT  = 6;  // specific level
    localparam int OCW3_RR_BIT  = 1;  // read register enable
    localparam int OCW3_RIS_BIT = 0;  // read ISR select
    localparam int ICW1_IC4_BIT = 0;
    localparam int ICW1_SNGL_BIT = 1;
    localparam int ICW4_AEOI_BIT = 1;

    // Low vector bits given on a spurious acknowledge
    localparam logic [2:0] SPURIOUS_LINE = 3'd7;

    // One result beat
    typedef struct packed {
        logic [7:0] read_data;
        logic       int_out;
        logic [7:0] vector;
        logic       vector_valid;
        logic       spurious;
    } result_t;

    // One-hot of the lowest set bit, zero when the byte is zero
    function automatic logic [7:0] lowest_onehot(input logic [7:0] v);
        lowest_onehot = v & (~v + 8'd1);
    endfunction

    // Index of the lowest set bit; only meaningful for a nonzero byte
    function automatic logic [2:0] lowest_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        lowest_index = idx;
    endfunction

    // Unmasked requests above the highest-priority line in service
    function automatic logic [7:0] eligible(input logic [7:0] irr,
                                            input logic [7:0] imr,
                                            input logic [7:0] isr);
        logic [7:0] below;
        below = (isr == 8'd0) ? 8'hFF : (lowest_onehot(isr) - 8'd1);
        eligible = irr & ~imr & below;
    endfunction

endpackage

`default_nettype wire

@@ hdl/pic_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pic_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        opcode,
    input  wire logic              port_select,
    input  wire logic [7:0]        write_data,
    input  wire logic [7:0]        irq_lines,
    output pic_pkg::result_t       result
);

    pic_pkg::phase_t phase_reg, phase_next;
    logic            expect_icw4_reg, expect_icw4_next;
    logic            single_mode_reg, single_mode_next;
    logic [4:0]      vector_base_reg, vector_base_next;
    logic [7:0]      cascade_word_reg, cascade_word_next;
    logic            auto_eoi_reg, auto_eoi_next;
    logic [7:0]      mask_reg, mask_next;
    logic [7:0]      request_reg, request_next;
    logic [7:0]      service_reg, service_next;
    logic            read_isr_sel_reg, read_isr_sel_next;

    logic [7:0]      elig;
    logic [7:0]      grant;

    // Next state and result for the current beat
    always_comb
    begin
        phase_next        = phase_reg;
        expect_icw4_next  = expect_icw4_reg;
        single_mode_next  = single_mode_reg;
        vector_base_next  = vector_base_reg;
        cascade_word_next = cascade_word_reg;
        auto_eoi_next     = auto_eoi_reg;
        mask_next         = mask_reg;
        request_next      = request_reg;
        service_next      = service_reg;
        read_isr_sel_next = read_isr_sel_reg;

        result = '0;
        elig   = pic_pkg::eligible(request_reg, mask_reg, service_reg);
        grant  = pic_pkg::lowest_onehot(elig);

        unique case (pic_pkg::op_t'(opcode))
            pic_pkg::OP_WRITE:
            begin
                if (port_select == pic_pkg::PORT_DATA)
                begin
                    // Data port: ICW2..ICW4 during init, mask afterwards
                    unique case (phase_reg)
                        pic_pkg::PH_ICW2:
                        begin
                            vector_base_next = write_data[7:3];
                            if (!single_mode_reg)
                                phase_next = pic_pkg::PH_ICW3;
                            else if (expect_icw4_reg)
                                phase_next = pic_pkg::PH_ICW4;
                            else
                                phase_next = pic_pkg::PH_READY;
                        end
                        pic_pkg::PH_ICW3:
                        begin
                            cascade_word_next = write_data;
                            phase_next = expect_icw4_reg ? pic_pkg::PH_ICW4
                                                         : pic_pkg::PH_READY;
                        end
                        pic_pkg::PH_ICW4:
                        begin
                            auto_eoi_next = write_data[pic_pkg::ICW4_AEOI_BIT];
                            phase_next    = pic_pkg::PH_READY;
                        end
                        default:
                        begin
                            mask_next = write_data;
                        end
                    endcase
                end
                else
                begin
                    // Command port: ICW1, OCW3, OCW2 in that order of decode
                    priority if (write_data[pic_pkg::ICW1_BIT])
                    begin
                        expect_icw4_next  = write_data[pic_pkg::ICW1_IC4_BIT];
                        single_mode_next  = write_data[pic_pkg::ICW1_SNGL_BIT];
                        mask_next         = 8'd0;
                        request_next      = 8'd0;
                        service_next      = 8'd0;
                        auto_eoi_next     = 1'b0;
                        read_isr_sel_next = 1'b0;
                        phase_next        = pic_pkg::PH_ICW2;
                    end
                    else if (write_data[pic_pkg::OCW3_BIT])
                    begin
                        if (write_data[pic_pkg::OCW3_RR_BIT])
                            read_isr_sel_next = write_data[pic_pkg::OCW3_RIS_BIT];
                    end
                    else if (write_data[pic_pkg::OCW2_EOI_BIT])
                    begin
                        if (write_data[pic_pkg::OCW2_SL_BIT])
                            service_next[write_data[2:0]] = 1'b0;
                        else
                            service_next = service_reg
                                         & ~pic_pkg::lowest_onehot(service_reg);
                    end
                end
            end
            pic_pkg::OP_READ:
            begin
                if (port_select == pic_pkg::PORT_DATA)
                    result.read_data = mask_reg;
                else
                    result.read_data = read_isr_sel_reg ? service_reg : request_reg;
            end
            pic_pkg::OP_SAMPLE:
            begin
                request_next = request_reg | irq_lines;
            end
            default:
            begin
                // Acknowledge: grant lowest eligible line or go spurious
                result.vector_valid = 1'b1;
                if (elig == 8'd0)
                begin
                    result.spurious = 1'b1;
                    result.vector   = {vector_base_reg, pic_pkg::SPURIOUS_LINE};
                end
                else
                begin
                    request_next = request_reg & ~grant;
                    if (!auto_eoi_reg)
                        service_next = service_reg | grant;
                    result.vector = {vector_base_reg, pic_pkg::lowest_index(elig)};
                end
            end
        endcase

        // Interrupt output reflects the state after this beat
        result.int_out = |pic_pkg::eligible(request_next, mask_next, service_next);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= pic_pkg::PH_READY;
            expect_icw4_reg  <= 1'b0;
            single_mode_reg  <= 1'b0;
            vector_base_reg  <= 5'd0;
            cascade_word_reg <= 8'd0;
            auto_eoi_reg     <= 1'b0;
            mask_reg         <= 8'hFF;
            request_reg      <= 8'd0;
            service_reg      <= 8'd0;
            read_isr_sel_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            expect_icw4_reg  <= expect_icw4_next;
            single_mode_reg  <= single_mode_next;
            vector_base_reg  <= vector_base_next;
            cascade_word_reg <= cascade_word_next;
            auto_eoi_reg     <= auto_eoi_next;
            mask_reg         <= mask_next;
            request_reg      <= request_next;
            service_reg      <= service_next;
            read_isr_sel_reg <= read_isr_sel_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pic_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pic_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_valid,
    output logic                   load_ready,
    input  wire pic_pkg::result_t  load_data,
    output logic                   hold_valid,
    input  wire logic              hold_ready,
    output pic_pkg::result_t       hold_data
);

    logic             valid_reg;
    pic_pkg::result_t data_reg;

    // Take a new beat when empty or when the held one leaves this cycle
    assign load_ready = !valid_reg || hold_ready;
    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

@@ hdl/programmable_interrupt_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 8259A-style interrupt controller with fixed priority (line 0 highest).
// Each input beat is one bus operation (write, read, line sample or
// acknowledge) and yields exactly one result beat. The controller state is
// updated at the edge that accepts a beat, and the result, including
// int_out as it stands after that operation, is held in a single output
// register. Throughput is one beat per clock while result_ready keeps the
// output register free; result_valid rises in the cycle after acceptance.
// The output register accepts a new beat in the same cycle its held result
// is taken, so result_ready low is the only thing that stalls the input side.
module programmable_interrupt_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic        port_select,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  irq_lines,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [7:0]       read_data,
    output logic             int_out,
    output logic [7:0]       vector,
    output logic             vector_valid,
    output logic             spurious
);

    logic             accept;
    pic_pkg::result_t step_result;
    pic_pkg::result_t held_result;

    assign accept = item_valid && item_ready;

    pic_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (opcode),
        .port_select (port_select),
        .write_data  (write_data),
        .irq_lines   (irq_lines),
        .result      (step_result)
    );

    pic_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .load_ready (item_ready),
        .load_data  (step_result),
        .hold_valid (result_valid),
        .hold_ready (result_ready),
        .hold_data  (held_result)
    );

    assign read_data    = held_result.read_data;
    assign int_out      = held_result.int_out;
    assign vector       = held_result.vector;
    assign vector_valid = held_result.vector_valid;
    assign spurious     = held_result.spurious;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    // Command bytes built from the package bit positions
    localparam logic [7:0] CMD_ICW1      = 8'(1 << pic_pkg::ICW1_BIT);
    localparam logic [7:0] CMD_OCW3      = 8'(1 << pic_pkg::OCW3_BIT);
    localparam logic [7:0] CMD_EOI       = 8'(1 << pic_pkg::OCW2_EOI_BIT);
    localparam logic [7:0] CMD_SEOI      = 8'((1 << pic_pkg::OCW2_EOI_BIT)
                                              | (1 << pic_pkg::OCW2_SL_BIT));
    localparam logic [7:0] CMD_ROTATE    = 8'h80;
    localparam logic [7:0] OCW3_RD_IRR   = CMD_OCW3 | 8'(1 << pic_pkg::OCW3_RR_BIT);
    localparam logic [7:0] OCW3_RD_ISR   = OCW3_RD_IRR | 8'(1 << pic_pkg::OCW3_RIS_BIT);
    localparam logic [7:0] ICW1_IC4      = 8'(1 << pic_pkg::ICW1_IC4_BIT);
    localparam logic [7:0] ICW1_SNGL     = 8'(1 << pic_pkg::ICW1_SNGL_BIT);
    localparam logic [7:0] ICW4_AEOI     = 8'(1 << pic_pkg::ICW4_AEOI_BIT);
    localparam int         WATCHDOG_MAX  = 2000;
    localparam int         RANDOM_PER_PHASE = 213;

    typedef struct {
        pic_pkg::op_t op;
        logic         port;
        logic [7:0]   wdata;
        logic [7:0]   lines;
    } bus_op_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [1:0] opcode = 2'd0;
    logic       port_select = 1'b0;
    logic [7:0] write_data = 8'd0;
    logic [7:0] irq_lines = 8'd0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] read_data;
    logic       int_out;
    logic [7:0] vector;
    logic       vector_valid;
    logic       spurious;

    bus_op_t          pending_ops[$];
    pic_pkg::result_t predicted_results[$];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    // Controller state as the predictor sees it
    pic_pkg::phase_t pic_phase = pic_pkg::PH_READY;
    logic            pic_need_icw4 = 1'b0;
    logic            pic_single = 1'b0;
    logic [4:0]      pic_base = 5'd0;
    logic [7:0]      pic_cascade = 8'd0;
    logic            pic_aeoi = 1'b0;
    logic [7:0]      pic_imr = 8'hFF;
    logic [7:0]      pic_irr = 8'd0;
    logic [7:0]      pic_isr = 8'd0;
    logic            pic_sel_isr = 1'b0;

    programmable_interrupt_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .port_select  (port_select),
        .write_data   (write_data),
        .irq_lines    (irq_lines),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .int_out      (int_out),
        .vector       (vector),
        .vector_valid (vector_valid),
        .spurious     (spurious)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Index of the lowest set bit, 8 for an empty byte
    function automatic int first_set(input logic [7:0] v);
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                return i;
            end
        end
        return 8;
    endfunction

    // Unmasked requests that outrank every line in service
    function automatic logic [7:0] grantable();
        int         top;
        logic [7:0] below;
        top = first_set(pic_isr);
        below = (top == 8) ? 8'hFF : 8'((1 << top) - 1);
        return pic_irr & ~pic_imr & below;
    endfunction

    function automatic void command_write(input logic [7:0] d);
        int n;
        if (d[pic_pkg::ICW1_BIT])
        begin
            pic_need_icw4 = d[pic_pkg::ICW1_IC4_BIT];
            pic_single = d[pic_pkg::ICW1_SNGL_BIT];
            pic_imr = 8'd0;
            pic_irr = 8'd0;
            pic_isr = 8'd0;
            pic_aeoi = 1'b0;
            pic_sel_isr = 1'b0;
            pic_phase = pic_pkg::PH_ICW2;
        end
        else if (d[pic_pkg::OCW3_BIT])
        begin
            if (d[pic_pkg::OCW3_RR_BIT])
            begin
                pic_sel_isr = d[pic_pkg::OCW3_RIS_BIT];
            end
        end
        else if (d[pic_pkg::OCW2_EOI_BIT])
        begin
            if (d[pic_pkg::OCW2_SL_BIT])
            begin
                pic_isr[d[2:0]] = 1'b0;
            end
            else
            begin
                n = first_set(pic_isr);
                if (n < 8)
                begin
                    pic_isr[n] = 1'b0;
                end
            end
        end
    endfunction

    function automatic void data_write(input logic [7:0] d);
        case (pic_phase)
            pic_pkg::PH_ICW2:
            begin
                pic_base = d[7:3];
                if (!pic_single)
                begin
                    pic_phase = pic_pkg::PH_ICW3;
                end
                else
                begin
                    pic_phase = pic_need_icw4 ? pic_pkg::PH_ICW4 : pic_pkg::PH_READY;
                end
            end
            pic_pkg::PH_ICW3:
            begin
                pic_cascade = d;
                pic_phase = pic_need_icw4 ? pic_pkg::PH_ICW4 : pic_pkg::PH_READY;
            end
            pic_pkg::PH_ICW4:
            begin
                pic_aeoi = d[pic_pkg::ICW4_AEOI_BIT];
                pic_phase = pic_pkg::PH_READY;
            end
            default:
            begin
                pic_imr = d;
            end
        endcase
    endfunction

    // Apply one bus operation to the predicted state and form its result beat
    function automatic pic_pkg::result_t pic_bus_cycle(input bus_op_t b);
        pic_pkg::result_t r;
        logic [7:0]       e;
        int               n;
        r = '0;
        case (b.op)
            pic_pkg::OP_WRITE:
            begin
                if (b.port == pic_pkg::PORT_DATA)
                begin
                    data_write(b.wdata);
                end
                else
                begin
                    command_write(b.wdata);
                end
            end
            pic_pkg::OP_READ:
            begin
                if (b.port == pic_pkg::PORT_DATA)
                begin
                    r.read_data = pic_imr;
                end
                else
                begin
                    r.read_data = pic_sel_isr ? pic_isr : pic_irr;
                end
            end
            pic_pkg::OP_SAMPLE:
            begin
                pic_irr = pic_irr | b.lines;
            end
            default:
            begin
                e = grantable();
                r.vector_valid = 1'b1;
                if (e == 8'd0)
                begin
                    r.spurious = 1'b1;
                    r.vector = {pic_base, pic_pkg::SPURIOUS_LINE};
                end
                else
                begin
                    n = first_set(e);
                    pic_irr[n] = 1'b0;
                    if (!pic_aeoi)
                    begin
                        pic_isr[n] = 1'b1;
                    end
                    r.vector = {pic_base, 3'(n)};
                end
            end
        endcase
        r.int_out = (grantable() != 8'd0);
        return r;
    endfunction

    // Stimulus helpers; fields the operation ignores carry random values
    task automatic put_write(input logic port, input logic [7:0] d);
        pending_ops.push_back('{pic_pkg::OP_WRITE, port, d, 8'($urandom)});
    endtask

    task automatic put_read(input logic port);
        pending_ops.push_back('{pic_pkg::OP_READ, port, 8'($urandom), 8'($urandom)});
    endtask

    task automatic put_sample(input logic [7:0] lines);
        pending_ops.push_back('{pic_pkg::OP_SAMPLE, 1'($urandom), 8'($urandom), lines});
    endtask

    task automatic put_ack();
        pending_ops.push_back('{pic_pkg::OP_ACK, 1'($urandom), 8'($urandom),
                               8'($urandom)});
    endtask

    // Sessions of service traffic, some preceded by an init sequence,
    // with a share of fully random beats as noise
    task automatic add_random(input int count);
        int         made;
        int         pick;
        logic [7:0] icw1;
        logic [7:0] cmd;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 35)
            begin
                icw1 = 8'($urandom) | CMD_ICW1;
                put_write(pic_pkg::PORT_CMD, icw1);
                put_write(pic_pkg::PORT_DATA, 8'($urandom));
                made += 2;
                if (!icw1[pic_pkg::ICW1_SNGL_BIT])
                begin
                    put_write(pic_pkg::PORT_DATA, 8'($urandom));
                    made++;
                end
                if (icw1[pic_pkg::ICW1_IC4_BIT])
                begin
                    put_write(pic_pkg::PORT_DATA, 8'($urandom));
                    made++;
                end
                put_write(pic_pkg::PORT_DATA, 8'($urandom & $urandom & $urandom));
                made++;
            end
            repeat ($urandom_range(8, 30))
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        put_sample(8'($urandom));
                    end
                    else
                    begin
                        put_sample(8'($urandom & $urandom & $urandom));
                    end
                end
                else if (pick < 50)
                begin
                    put_ack();
                end
                else if (pick < 62)
                begin
                    case ($urandom_range(2))
                        0: cmd = CMD_EOI | (8'($urandom) & (CMD_ROTATE | 8'h07));
                        1: cmd = CMD_SEOI | (8'($urandom) & (CMD_ROTATE | 8'h07));
                        default: cmd = 8'($urandom) & ~(CMD_EOI | CMD_ICW1 | CMD_OCW3);
                    endcase
                    put_write(pic_pkg::PORT_CMD, cmd);
                end
                else if (pick < 70)
                begin
                    put_write(pic_pkg::PORT_CMD, (8'($urandom) & ~CMD_ICW1) | CMD_OCW3);
                end
                else if (pick < 85)
                begin
                    put_read(1'($urandom));
                end
                else if (pick < 92)
                begin
                    put_write(pic_pkg::PORT_DATA, 8'($urandom & $urandom));
                end
                else
                begin
                    pending_ops.push_back('{pic_pkg::op_t'($urandom_range(3)),
                                           1'($urandom), 8'($urandom), 8'($urandom)});
                end
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || item_valid || predicted_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Input driver: predict on each accepted beat, then present the next one
    always @(posedge clk)
    begin : input_driver
        bus_op_t nxt;
        logic    taken;
        taken = item_valid && item_ready;
        if (taken)
        begin
            predicted_results.push_back(pic_bus_cycle('{pic_pkg::op_t'(opcode),
                                                        port_select, write_data,
                                                        irq_lines}));
        end
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || taken)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_ops.pop_front();
                item_valid <= 1'b1;
                opcode <= nxt.op;
                port_select <= nxt.port;
                write_data <= nxt.wdata;
                irq_lines <= nxt.lines;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted beat with the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        pic_pkg::result_t got;
        pic_pkg::result_t want;
        if (result_valid && result_ready)
        begin
            got = {read_data, int_out, vector, vector_valid, spurious};
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR %0t: unexpected result beat %p", $realtime, got);
                end
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"ERROR %0t: rd exp %h got %h, int exp %b got %b, ",
                                  "vec exp %h got %h, vval exp %b got %b, ",
                                  "spur exp %b got %b"},
                                 $realtime, want.read_data, got.read_data,
                                 want.int_out, got.int_out, want.vector, got.vector,
                                 want.vector_valid, got.vector_valid,
                                 want.spurious, got.spurious);
                    end
                end
            end
        end
        result_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, init corner cases, EOI flavors, auto-EOI
        put_read(pic_pkg::PORT_CMD);
        put_read(pic_pkg::PORT_DATA);
        put_ack();                                       // spurious, base 0
        put_sample(8'hFF);
        put_ack();                                       // all masked: spurious
        put_write(pic_pkg::PORT_CMD, CMD_ICW1 | 8'h0F);  // single, IC4
        put_read(pic_pkg::PORT_DATA);                    // read during init
        put_write(pic_pkg::PORT_CMD, OCW3_RD_ISR);       // OCW3 during init
        put_write(pic_pkg::PORT_DATA, 8'hFF);            // ICW2: low bits dropped
        put_write(pic_pkg::PORT_DATA, 8'hFF & ~ICW4_AEOI); // ICW4: other bits ignored
        put_sample(8'hFF);
        put_ack();                                       // line 0
        put_read(pic_pkg::PORT_CMD);                     // ISR
        put_write(pic_pkg::PORT_CMD, CMD_ROTATE | 8'h47); // EOI bit clear: no-op
        put_write(pic_pkg::PORT_CMD, CMD_OCW3 | 8'h01);  // RR clear: select kept
        put_write(pic_pkg::PORT_CMD, CMD_EOI | CMD_ROTATE); // non-specific EOI
        put_ack();                                       // line 1
        put_ack();                                       // lower than service: spurious
        put_write(pic_pkg::PORT_CMD, CMD_SEOI | 8'h01);  // specific EOI line 1
        put_write(pic_pkg::PORT_CMD, CMD_EOI);           // ISR empty: nothing
        put_write(pic_pkg::PORT_CMD, OCW3_RD_IRR);
        put_write(pic_pkg::PORT_CMD, CMD_ICW1);          // cascade, no ICW4
        put_write(pic_pkg::PORT_DATA, 8'h07);
        put_write(pic_pkg::PORT_CMD, CMD_ICW1 | ICW1_IC4); // restart mid-init
        put_write(pic_pkg::PORT_DATA, 8'h48);
        put_write(pic_pkg::PORT_DATA, 8'hA5);            // ICW3
        put_write(pic_pkg::PORT_DATA, ICW4_AEOI | 8'h01); // auto-EOI
        put_sample(8'h80);
        put_ack();
        put_read(pic_pkg::PORT_CMD);
        wait_drained();

        // Random phases with different idle mixes; drain between them
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            add_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
